// ===== rtl/mmcp_pkg.sv =====
// shared types and constants for the machine control command parser
package mmcp_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 5;
	localparam int QDEPTH      = 4;
	localparam int PTR_W       = 2;

	localparam logic [7:0] ALL_CALL           = 8'h7f;
	localparam logic [7:0] CMD_MASKED_WRITE   = 8'h41;
	localparam logic [7:0] CMD_LOCATE         = 8'h44;
	localparam logic [7:0] CMD_SHUTTLE        = 8'h47;
	localparam logic [7:0] TARGET_TRACK_READY = 8'h4f;

	localparam logic [4:0] EV_LOCATE    = 5'd13;
	localparam logic [4:0] EV_SHUTTLE   = 5'd14;
	localparam logic [4:0] EV_TRACK     = 5'd15;
	localparam logic [4:0] EV_UNIMPL    = 5'd16;
	localparam logic [4:0] EV_UNKNOWN   = 5'd17;
	localparam logic [4:0] EV_LOCATE_IF = 5'd18;
	localparam logic [4:0] EV_MW_TARGET = 5'd19;

	typedef enum logic [1:0] {
		HDR_HEADER,
		HDR_DEVICE,
		HDR_SUBID,
		HDR_BODY
	} hdr_pos_t;

	typedef enum logic [1:0] {
		JOB_EVENT,
		JOB_LOCATE,
		JOB_SHUTTLE,
		JOB_TRACKS
	} job_kind_t;

	typedef struct packed {
		job_kind_t       kind;
		logic [4:0]      code;
		logic [4:0][6:0] args;
		logic [6:0]      trk_vec;
		logic [6:0]      trk_data;
		logic [5:0]      trk_base;
	} job_t;

endpackage

// ===== rtl/mmcp_front.sv =====
// front end: header check and command decode, one byte per cycle unless the job queue is full
module mmcp_front #(
	parameter int MAX_TRACKS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_start,
	input  logic               in_end,
	input  logic               q_full,
	output logic               q_push,
	output mmcp_pkg::job_t     q_job
);

	mmcp_pkg::hdr_pos_t hdr_q, n_hdr, hdr_sel;
	logic       acc_q, n_acc;
	logic [7:0] cmd_q, n_cmd;
	logic [7:0] left_q, n_left, left_d;
	logic [2:0] fidx_q, n_fidx, idx;
	logic [7:0] arg_q [5];
	logic [7:0] n_arg [5];
	logic [6:0] bn_q, n_bn;
	logic [6:0] mask_q, n_mask;
	logic [6:0] dev_q;
	logic       in_fire;
	logic [9:0] bn7;
	logic [11:0] base;
	logic [11:0] trk;
	logic [6:0] vec;

	function automatic logic is_unimpl(input logic [7:0] c);
		logic r;
		r = (c == 8'h40) || (c == 8'h42) || (c == 8'h43) || (c == 8'h45) || (c == 8'h46);
		r = r || ((c >= 8'h48) && (c <= 8'h55)) || (c == 8'h7c) || (c == 8'h7f);
		return r;
	endfunction

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= 7'd1;
		end else if (cfg_wr_en) begin
			dev_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= mmcp_pkg::HDR_HEADER;
			acc_q  <= 1'b0;
			cmd_q  <= 8'd0;
			left_q <= 8'd0;
			fidx_q <= 3'd0;
			bn_q   <= 7'd0;
			mask_q <= 7'd0;
		end else begin
			hdr_q  <= n_hdr;
			acc_q  <= n_acc;
			cmd_q  <= n_cmd;
			left_q <= n_left;
			fidx_q <= n_fidx;
			bn_q   <= n_bn;
			mask_q <= n_mask;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 5; i++) begin
			arg_q[i] <= n_arg[i];
		end
	end

	// track range from the bitmap byte number
	always_comb begin
		bn7  = {n_bn, 3'b000} - {3'b000, n_bn};
		base = {2'b00, bn7} - 12'd5;
		trk  = base;
		vec  = '0;
		for (int i = 0; i < 7; i++) begin
			trk    = base + 12'(i);
			vec[i] = n_mask[i] && !trk[11] && (trk < 12'(MAX_TRACKS));
		end
	end

	always_comb begin
		n_hdr  = hdr_q;
		n_acc  = acc_q;
		n_cmd  = cmd_q;
		n_left = left_q;
		n_fidx = fidx_q;
		n_bn   = bn_q;
		n_mask = mask_q;
		for (int i = 0; i < 5; i++) begin
			n_arg[i] = arg_q[i];
		end
		idx     = fidx_q;
		left_d  = left_q;
		q_push  = 1'b0;
		q_job   = '0;
		hdr_sel = in_start ? mmcp_pkg::HDR_HEADER : hdr_q;
		if (in_fire) begin
			if (in_start) begin
				n_acc  = 1'b0;
				n_left = 8'd0;
				n_fidx = 3'd0;
			end
			unique case (hdr_sel)
				mmcp_pkg::HDR_HEADER: begin
					n_hdr = mmcp_pkg::HDR_DEVICE;
				end
				mmcp_pkg::HDR_DEVICE: begin
					n_acc = (in_byte == mmcp_pkg::ALL_CALL) || (in_byte == {1'b0, dev_q});
					n_hdr = mmcp_pkg::HDR_SUBID;
				end
				mmcp_pkg::HDR_SUBID: begin
					n_hdr  = mmcp_pkg::HDR_BODY;
					n_left = 8'd0;
					n_fidx = 3'd0;
				end
				mmcp_pkg::HDR_BODY: begin
					if (acc_q && left_q == 8'd0) begin
						n_cmd  = in_byte;
						n_fidx = 3'd1;
						q_job.kind = mmcp_pkg::JOB_EVENT;
						priority if (in_byte >= 8'h01 && in_byte <= 8'h0d) begin
							q_push     = 1'b1;
							q_job.code = 5'(in_byte - 8'd1);
						end else if (in_byte == mmcp_pkg::CMD_MASKED_WRITE) begin
							n_left = 8'd1;
						end else if (in_byte == mmcp_pkg::CMD_LOCATE) begin
							n_left = 8'd3;
						end else if (in_byte == mmcp_pkg::CMD_SHUTTLE) begin
							n_left = 8'd4;
						end else if (is_unimpl(in_byte)) begin
							q_push     = 1'b1;
							q_job.code = mmcp_pkg::EV_UNIMPL;
						end else begin
							q_push     = 1'b1;
							q_job.code = mmcp_pkg::EV_UNKNOWN;
						end
					end else if (acc_q) begin
						left_d = left_q - 8'd1;
						n_fidx = (idx < 3'd7) ? idx + 3'd1 : 3'd7;
						priority if (cmd_q == mmcp_pkg::CMD_MASKED_WRITE) begin
							if (idx == 3'd1) begin
								left_d = (in_byte == 8'd0) ? 8'd1 : in_byte;
							end else if (idx == 3'd2) begin
								n_arg[0] = in_byte;
								if (in_byte == mmcp_pkg::TARGET_TRACK_READY && left_d < 8'd3) begin
									left_d = 8'd3;
								end
							end else if (idx == 3'd3) begin
								n_bn = in_byte[6:0];
							end else if (idx == 3'd4) begin
								n_mask = in_byte[6:0];
							end else if (idx == 3'd5) begin
								n_arg[1] = {1'b0, in_byte[6:0]};
							end
						end else if (cmd_q == mmcp_pkg::CMD_LOCATE) begin
							if (idx == 3'd2 && in_byte != 8'd0) begin
								left_d = left_d + 8'd4;
							end else if (idx >= 3'd3) begin
								n_arg[3'(idx - 3'd3)] = in_byte;
							end
						end else if (cmd_q == mmcp_pkg::CMD_SHUTTLE) begin
							if (idx >= 3'd2 && idx <= 3'd4) begin
								n_arg[3'(idx - 3'd2)] = in_byte;
							end
						end
						n_left = left_d;
						for (int i = 0; i < 5; i++) begin
							q_job.args[i] = n_arg[i][6:0];
						end
						if (left_d == 8'd0) begin
							priority if (cmd_q == mmcp_pkg::CMD_MASKED_WRITE) begin
								if (n_arg[0] == mmcp_pkg::TARGET_TRACK_READY) begin
									q_push         = vec != 7'd0;
									q_job.kind     = mmcp_pkg::JOB_TRACKS;
									q_job.code     = mmcp_pkg::EV_TRACK;
									q_job.trk_vec  = vec;
									q_job.trk_data = n_arg[1][6:0];
									q_job.trk_base = base[5:0];
								end else begin
									q_push     = 1'b1;
									q_job.kind = mmcp_pkg::JOB_EVENT;
									q_job.code = mmcp_pkg::EV_MW_TARGET;
								end
							end else if (cmd_q == mmcp_pkg::CMD_LOCATE) begin
								q_push = 1'b1;
								if (n_fidx >= 3'd7) begin
									q_job.kind = mmcp_pkg::JOB_LOCATE;
									q_job.code = mmcp_pkg::EV_LOCATE;
								end else begin
									q_job.kind = mmcp_pkg::JOB_EVENT;
									q_job.code = mmcp_pkg::EV_LOCATE_IF;
								end
							end else if (cmd_q == mmcp_pkg::CMD_SHUTTLE) begin
								q_push     = 1'b1;
								q_job.kind = mmcp_pkg::JOB_SHUTTLE;
								q_job.code = mmcp_pkg::EV_SHUTTLE;
							end
						end
					end
				end
			endcase
			if (in_end) begin
				n_hdr  = mmcp_pkg::HDR_BODY;
				n_acc  = 1'b0;
				n_left = 8'd0;
				n_fidx = 3'd0;
			end
		end
	end

endmodule

// ===== rtl/mmcp_fifo.sv =====
// short job queue between decode and event output
module mmcp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mmcp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output mmcp_pkg::job_t head,
	output logic           empty
);

	mmcp_pkg::job_t mem_q [mmcp_pkg::QDEPTH];
	logic [mmcp_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mmcp_pkg::PTR_W:0]   cnt_q;

	assign full  = cnt_q == (mmcp_pkg::PTR_W + 1)'(mmcp_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/mmcp_back.sv =====
// back end: turns queued jobs into events, one per cycle unless m_axis stalls
module mmcp_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmcp_pkg::job_t                       head,
	input  logic                                 empty,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mmcp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [mmcp_pkg::OUT_TUSER_W-1:0]     m_tuser,
	output logic                                 m_tlast
);

	logic       busy_q;
	logic [6:0] pend_q;
	logic [6:0] cur_vec, rest;
	logic [2:0] sel;
	logic       last, fire;
	logic [16:0] raw;
	logic [23:0] speed;
	logic [mmcp_pkg::OUT_TDATA_W-1:0] ev_data;
	logic       m_valid_q, m_last_q;
	logic [mmcp_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic [mmcp_pkg::OUT_TUSER_W-1:0] m_user_q;

	assign cur_vec = busy_q ? pend_q : head.trk_vec;
	assign rest    = cur_vec & (cur_vec - 7'd1);
	assign last    = (head.kind != mmcp_pkg::JOB_TRACKS) || (rest == 7'd0);
	assign fire    = !empty && (!m_valid_q || m_tready);
	assign pop     = fire && last;

	always_comb begin
		sel = 3'd0;
		for (int i = 6; i >= 0; i--) begin
			if (cur_vec[i]) begin
				sel = 3'(i);
			end
		end
	end

	assign raw   = {head.args[0][2:0], head.args[1], head.args[2]};
	assign speed = 24'({7'd0, raw} << head.args[0][5:3]);

	// tdata: fwd, speed, track, ready, hours, minutes, seconds, frames, subframes
	always_comb begin
		ev_data = '0;
		unique case (head.kind)
			mmcp_pkg::JOB_EVENT: begin
				ev_data = '0;
			end
			mmcp_pkg::JOB_LOCATE: begin
				ev_data[38:32] = head.args[0];
				ev_data[45:39] = head.args[1];
				ev_data[52:46] = head.args[2];
				ev_data[59:53] = head.args[3];
				ev_data[66:60] = head.args[4];
			end
			mmcp_pkg::JOB_SHUTTLE: begin
				ev_data[0]    = !head.args[0][6];
				ev_data[24:1] = speed;
			end
			mmcp_pkg::JOB_TRACKS: begin
				ev_data[30:25] = head.trk_base + 6'(sel);
				ev_data[31]    = head.trk_data[sel];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			if (fire) begin
				m_valid_q <= 1'b1;
				busy_q    <= !last;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= ev_data;
			m_user_q <= head.code;
			m_last_q <= last;
			pend_q   <= rest;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== rtl/mmcp_top.sv =====
// top level of the machine control command parser
//
//  channel   | dir | request                          | sideband
//  s_axis    | in  | one message byte                 | tuser start, tlast end
//  m_axis    | out | one event                        | tuser code, tlast last of byte
//  cfg_wr    | in  | own device id                    | no read-back
//
// one byte per cycle at the input; a byte that completes a command reaches
// m_axis through the job queue and the output register; a track bitmap write gives
// up to seven events, one per cycle from the back end unless m_axis stalls
// the input stalls only while the four-entry job queue is full
// reset clears the parser, the queue and the output register; device id resets to 1
module mmc_command_parser_top #(
	parameter int MAX_TRACKS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [6:0]                           cfg_wr_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mmcp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // data_byte
	input  logic [0:0]                           s_axis_tuser,  // start_of_message
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// shuttle_forward, shuttle_speed_q14, track_number, track_ready, locate_hours,
	// locate_minutes, locate_seconds, locate_frames, locate_subframes, zero pad
	output logic [mmcp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic [mmcp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // event_code
	output logic                                 m_axis_tlast
);

	logic           q_push, q_full, q_pop, q_empty;
	mmcp_pkg::job_t q_job, q_head;

	mmcp_front #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_start    (s_axis_tuser[0]),
		.in_end      (s_axis_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	mmcp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	mmcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty job queue");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != mmcp_pkg::EV_TRACK) |-> m_axis_tlast)
		else $error("non-track event without last flag");

	a_track_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == mmcp_pkg::EV_TRACK) |-> m_axis_tdata[24:0] == '0)
		else $error("track event carries shuttle fields");

endmodule

// ===== tb/testbench.sv =====
// testbench for the machine control command parser: random and directed sysex messages, scored
`timescale 1ns / 100ps

module testbench;

	localparam int TRACKS      = 64;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 60;

	localparam logic [7:0] SUBID_COMMAND     = 8'h06;
	localparam logic [7:0] CMD_SIMPLE_FIRST  = 8'h01;
	localparam logic [7:0] CMD_SIMPLE_LAST   = 8'h0d;
	localparam logic [7:0] CMD_WRITE         = 8'h40;
	localparam logic [7:0] CMD_READ          = 8'h42;
	localparam logic [7:0] CMD_UPDATE        = 8'h43;
	localparam logic [7:0] CMD_VARIABLE_PLAY = 8'h45;
	localparam logic [7:0] CMD_SEARCH        = 8'h46;
	localparam logic [7:0] CMD_GROUP_FIRST   = 8'h48;
	localparam logic [7:0] CMD_GROUP_LAST    = 8'h55;
	localparam logic [7:0] CMD_WAIT          = 8'h7c;
	localparam logic [7:0] CMD_RESUME        = 8'h7f;
	localparam logic [7:0] LOCATE_IF_SUB     = 8'h00;

	typedef struct packed {
		logic [4:0]  code;
		logic        forward;
		logic [23:0] speed;
		logic [5:0]  track;
		logic        ready;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [6:0]  frames;
		logic [6:0]  subframes;
		logic        last;
	} mmc_event_t;

	class mmc_event_scoreboard;
		logic [6:0] device_id;
		mmcp_pkg::hdr_pos_t hdr;
		bit         accepted;
		logic [7:0] cmd;
		logic [7:0] left;
		logic [2:0] fidx;
		logic [7:0] args [5];
		logic [6:0] bm_byte;
		logic [6:0] bm_mask;
		bit         ready_store [TRACKS];
		mmc_event_t step_events[$];
		mmc_event_t expected_events[$];
		int         errors;

		function new();
			device_id = 7'd1;
			hdr = mmcp_pkg::HDR_HEADER;
			accepted = 0;
			cmd = '0;
			left = '0;
			fidx = '0;
			foreach (args[i]) args[i] = '0;
			bm_byte = '0;
			bm_mask = '0;
			foreach (ready_store[i]) ready_store[i] = 0;
			errors = 0;
		endfunction

		static function bit is_unimpl(logic [7:0] c);
			return c == CMD_WRITE || c == CMD_READ || c == CMD_UPDATE ||
				c == CMD_VARIABLE_PLAY || c == CMD_SEARCH ||
				(c >= CMD_GROUP_FIRST && c <= CMD_GROUP_LAST) ||
				c == CMD_WAIT || c == CMD_RESUME;
		endfunction

		function void load_own_id(logic [6:0] v);
			device_id = v;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function void add_event(logic [4:0] code);
			mmc_event_t e;
			e = '0;
			e.code = code;
			step_events.push_back(e);
		endfunction

		function void finish_command();
			mmc_event_t e;
			int         base;
			int         t;
			logic [6:0] sh;
			logic [31:0] raw;
			if (cmd == mmcp_pkg::CMD_MASKED_WRITE) begin
				if (args[0] == mmcp_pkg::TARGET_TRACK_READY) begin
					base = int'(bm_byte) * 7 - 5;
					for (int i = 0; i < 7; i++) begin
						t = base + i;
						if (bm_mask[i] && t >= 0 && t < TRACKS) begin
							ready_store[t] = args[1][i];
							e = '0;
							e.code = mmcp_pkg::EV_TRACK;
							e.track = t[5:0];
							e.ready = args[1][i];
							step_events.push_back(e);
						end
					end
				end else begin
					add_event(mmcp_pkg::EV_MW_TARGET);
				end
			end else if (cmd == mmcp_pkg::CMD_LOCATE) begin
				if (fidx >= 3'd7) begin
					e = '0;
					e.code = mmcp_pkg::EV_LOCATE;
					e.hours = args[0][6:0];
					e.minutes = args[1][6:0];
					e.seconds = args[2][6:0];
					e.frames = args[3][6:0];
					e.subframes = args[4][6:0];
					step_events.push_back(e);
				end else begin
					add_event(mmcp_pkg::EV_LOCATE_IF);
				end
			end else if (cmd == mmcp_pkg::CMD_SHUTTLE) begin
				sh = args[0][6:0];
				raw = {15'd0, sh[2:0], args[1][6:0], args[2][6:0]};
				e = '0;
				e.code = mmcp_pkg::EV_SHUTTLE;
				e.forward = !sh[6];
				e.speed = 24'(raw << sh[5:3]);
				step_events.push_back(e);
			end
		endfunction

		function void command_byte(logic [7:0] b);
			logic [2:0] idx;
			if (left == 0) begin
				cmd = b;
				fidx = 3'd1;
				if (b >= CMD_SIMPLE_FIRST && b <= CMD_SIMPLE_LAST)
					add_event(5'(b - CMD_SIMPLE_FIRST));
				else if (b == mmcp_pkg::CMD_MASKED_WRITE)
					left = 8'd1;
				else if (b == mmcp_pkg::CMD_LOCATE)
					left = 8'd3;
				else if (b == mmcp_pkg::CMD_SHUTTLE)
					left = 8'd4;
				else if (is_unimpl(b))
					add_event(mmcp_pkg::EV_UNIMPL);
				else
					add_event(mmcp_pkg::EV_UNKNOWN);
				return;
			end
			idx = fidx;
			left = left - 8'd1;
			fidx = (idx < 3'd7) ? idx + 3'd1 : 3'd7;
			if (cmd == mmcp_pkg::CMD_MASKED_WRITE) begin
				case (idx)
					3'd1: left = (b == 0) ? 8'd1 : b;
					3'd2: begin
						args[0] = b;
						if (b == mmcp_pkg::TARGET_TRACK_READY && left < 8'd3)
							left = 8'd3;
					end
					3'd3: bm_byte = b[6:0];
					3'd4: bm_mask = b[6:0];
					3'd5: args[1] = {1'b0, b[6:0]};
					default: ;
				endcase
			end else if (cmd == mmcp_pkg::CMD_LOCATE) begin
				if (idx == 3'd2 && b != 0)
					left = left + 8'd4;
				else if (idx >= 3'd3)
					args[idx - 3'd3] = b;
			end else if (cmd == mmcp_pkg::CMD_SHUTTLE) begin
				if (idx >= 3'd2 && idx <= 3'd4)
					args[idx - 3'd2] = b;
			end
			if (left == 0)
				finish_command();
		endfunction

		function void note_byte(logic [7:0] b, bit sop, bit eop);
			step_events.delete();
			if (sop) begin
				hdr = mmcp_pkg::HDR_HEADER;
				accepted = 0;
				left = '0;
				fidx = '0;
			end
			case (hdr)
				mmcp_pkg::HDR_HEADER: hdr = mmcp_pkg::HDR_DEVICE;
				mmcp_pkg::HDR_DEVICE: begin
					accepted = (b == mmcp_pkg::ALL_CALL) || (b == {1'b0, device_id});
					hdr = mmcp_pkg::HDR_SUBID;
				end
				mmcp_pkg::HDR_SUBID: begin
					hdr = mmcp_pkg::HDR_BODY;
					left = '0;
					fidx = '0;
				end
				default: if (accepted) command_byte(b);
			endcase
			if (eop) begin
				hdr = mmcp_pkg::HDR_BODY;
				accepted = 0;
				left = '0;
				fidx = '0;
			end
			if (step_events.size() > 0)
				step_events[step_events.size() - 1].last = 1'b1;
			foreach (step_events[i]) expected_events.push_back(step_events[i]);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_event(mmc_event_t got);
			mmc_event_t want;
			if (expected_events.size() == 0) begin
				$display("%0t: event code %0d expected none actual %0h", $time, got.code, got);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("event_code", want.code, got.code);
			compare_field("shuttle_forward", want.forward, got.forward);
			compare_field("shuttle_speed_q14", want.speed, got.speed);
			compare_field("track_number", want.track, got.track);
			compare_field("track_ready", want.ready, got.ready);
			compare_field("locate_hours", want.hours, got.hours);
			compare_field("locate_minutes", want.minutes, got.minutes);
			compare_field("locate_seconds", want.seconds, got.seconds);
			compare_field("locate_frames", want.frames, got.frames);
			compare_field("locate_subframes", want.subframes, got.subframes);
			compare_field("last_result", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [6:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [mmcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [mmcp_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
	logic        m_axis_tlast;

	mmc_event_scoreboard sb = new();

	int          burst_left = 0;
	bit          eager = 0;
	int          random_items = 0;
	logic [6:0]  cur_dev = 7'd1;
	int unsigned stall_count = 0;
	int          stall_mode = 0;
	int          quiet = 0;

	mmc_command_parser_top #(
		.MAX_TRACKS(TRACKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		stall_count <= stall_count + 1;
		if (stall_count % 48 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (stall_count % 4 == 0);
			default: m_axis_tready <= (stall_count % 11 >= 5);
		endcase
	end

	always @(posedge clk) begin : event_monitor
		mmc_event_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.code = m_axis_tuser;
			got.forward = m_axis_tdata[0];
			got.speed = m_axis_tdata[24:1];
			got.track = m_axis_tdata[30:25];
			got.ready = m_axis_tdata[31];
			got.hours = m_axis_tdata[38:32];
			got.minutes = m_axis_tdata[45:39];
			got.seconds = m_axis_tdata[52:46];
			got.frames = m_axis_tdata[59:53];
			got.subframes = m_axis_tdata[66:60];
			got.last = m_axis_tlast;
			sb.check_event(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task send_byte(input logic [7:0] b, input bit sop, input bit eop);
		if (!eager && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		if (!eager)
			burst_left--;
		s_axis_tdata <= b;
		s_axis_tuser <= sop;
		s_axis_tlast <= eop;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b, sop, eop);
	endtask

	task send_message(input logic [7:0] m[$], input bit sop, input bit eop);
		foreach (m[i]) begin
			send_byte(m[i], sop && i == 0, eop && i == m.size() - 1);
			random_items++;
		end
	endtask

	task write_device_id(input logic [6:0] v);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.load_own_id(v);
		cur_dev = v;
	endtask

	task run_message();
		logic [7:0] m[$];
		logic [7:0] c;
		logic [7:0] t;
		int         sel;
		int         rem;
		int         cut;
		bit         closed;
		bit         eop;
		closed = 0;
		eager = ($urandom_range(0, 3) == 0);
		m.push_back(mmcp_pkg::ALL_CALL);
		sel = $urandom_range(0, 9);
		if (sel < 4)
			m.push_back(mmcp_pkg::ALL_CALL);
		else if (sel < 8)
			m.push_back({1'b0, cur_dev});
		else
			m.push_back(8'($urandom_range(0, 255)));
		m.push_back(SUBID_COMMAND);
		repeat ($urandom_range(1, 4)) begin
			if (!closed) begin
				sel = $urandom_range(0, 19);
				if (sel < 5) begin
					m.push_back(8'($urandom_range(CMD_SIMPLE_FIRST, CMD_SIMPLE_LAST)));
				end else if (sel < 8) begin
					m.push_back(mmcp_pkg::CMD_LOCATE);
					m.push_back(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 2) == 0) begin
						m.push_back(LOCATE_IF_SUB);
						m.push_back(8'($urandom_range(0, 255)));
					end else begin
						m.push_back(8'($urandom_range(1, 255)));
						repeat (5) m.push_back(8'($urandom_range(0, 255)));
					end
				end else if (sel < 11) begin
					m.push_back(mmcp_pkg::CMD_SHUTTLE);
					repeat (4) m.push_back(8'($urandom_range(0, 255)));
				end else if (sel < 16) begin
					m.push_back(mmcp_pkg::CMD_MASKED_WRITE);
					if ($urandom_range(0, 19) == 0) begin
						// count far beyond the message, cut by the end marker or the next start
						m.push_back(8'($urandom_range(128, 255)));
						repeat ($urandom_range(2, 6)) m.push_back(8'($urandom_range(0, 255)));
						closed = 1;
					end else if ($urandom_range(0, 4) == 0) begin
						c = 8'($urandom_range(0, 5));
						m.push_back(c);
						do t = 8'($urandom_range(0, 255));
						while (t == mmcp_pkg::TARGET_TRACK_READY);
						m.push_back(t);
						rem = ((c == 0) ? 1 : int'(c)) - 1;
						repeat (rem) m.push_back(8'($urandom_range(0, 255)));
					end else begin
						c = 8'($urandom_range(0, 7));
						m.push_back(c);
						m.push_back(mmcp_pkg::TARGET_TRACK_READY);
						if ($urandom_range(0, 3) == 0)
							m.push_back(8'($urandom_range(0, 255)));
						else
							m.push_back(8'($urandom_range(0, 10)));
						m.push_back(8'($urandom_range(0, 255)));
						m.push_back(8'($urandom_range(0, 255)));
						rem = ((c == 0) ? 1 : int'(c)) - 1;
						rem = (rem < 3) ? 0 : rem - 3;
						repeat (rem) m.push_back(8'($urandom_range(0, 255)));
					end
				end else if (sel < 18) begin
					do c = 8'($urandom_range(0, 255));
					while (!mmc_event_scoreboard::is_unimpl(c));
					m.push_back(c);
				end else begin
					do c = 8'($urandom_range(0, 255));
					while ((c >= CMD_SIMPLE_FIRST && c <= CMD_SIMPLE_LAST) ||
						c == mmcp_pkg::CMD_MASKED_WRITE || c == mmcp_pkg::CMD_LOCATE ||
						c == mmcp_pkg::CMD_SHUTTLE || mmc_event_scoreboard::is_unimpl(c));
					m.push_back(c);
				end
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, m.size());
			m = m[0:cut - 1];
		end
		eop = ($urandom_range(0, 9) != 0);
		send_message(m, 1'b1, eop);
		// bytes after the end marker are ignored until the next start
		if (eop && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2))
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	task run_phase();
		int target;
		target = random_items + PHASE_ITEMS;
		while (random_items < target)
			run_message();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// first byte after reset is taken as the header even without start
		send_message('{mmcp_pkg::ALL_CALL, mmcp_pkg::ALL_CALL, SUBID_COMMAND,
			CMD_SIMPLE_FIRST, CMD_SIMPLE_LAST}, 1'b0, 1'b1);
		send_message('{mmcp_pkg::ALL_CALL, 8'h01, SUBID_COMMAND, mmcp_pkg::CMD_SHUTTLE,
			8'h03, 8'h7f, 8'hff, 8'hff}, 1'b1, 1'b1);
		send_message('{mmcp_pkg::ALL_CALL, 8'h02, SUBID_COMMAND, CMD_SIMPLE_FIRST},
			1'b1, 1'b1);
		send_message('{mmcp_pkg::ALL_CALL, mmcp_pkg::ALL_CALL, SUBID_COMMAND,
			mmcp_pkg::CMD_MASKED_WRITE, 8'h00, mmcp_pkg::TARGET_TRACK_READY, 8'h01,
			8'hff, 8'hff, 8'hff}, 1'b1, 1'b1);
		send_byte(CMD_SIMPLE_FIRST, 1'b0, 1'b0);

		write_device_id(7'd0);
		run_phase();
		write_device_id(7'd127);
		run_phase();
		write_device_id(7'($urandom_range(2, 126)));
		run_phase();

		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mmcp_pkg.sv
rtl/mmcp_front.sv
rtl/mmcp_fifo.sv
rtl/mmcp_back.sv
rtl/mmcp_top.sv
tb/testbench.sv
